/* hw/rtl/trg_pkg.sv */
// shared types and constants of the task router
`default_nettype none
package trg_pkg;

  localparam int MAX_WORKERS   = 64;
  localparam int GROUP_ENTRIES = 16;
  localparam int CONTAINERS    = 16;

  localparam int SLOT_W   = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
  localparam int WORKER_W = 6;
  localparam int CNT_W    = 7;
  localparam int CIDX_W   = 4;
  localparam int GID_W    = 64;
  localparam int IO_W     = 48;
  localparam int POOL_W   = 32;
  localparam int METHOD_W = 16;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IO_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADMIN_POOL    = 2'd2;

  // network methods of the admin pool
  localparam logic [METHOD_W-1:0] METHOD_NET_A = 16'd14;
  localparam logic [METHOD_W-1:0] METHOD_NET_B = 16'd15;
  localparam logic [METHOD_W-1:0] METHOD_NET_C = 16'd20;
  localparam logic [METHOD_W-1:0] METHOD_NET_D = 16'd21;

  typedef logic [SLOT_W-1:0] slot_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic                    vld;
    logic [CIDX_W-1:0]       cidx;
    logic [GID_W-1:0]        gid;
    logic                    hit;
    logic [WORKER_W-1:0]     worker;
    logic                    free_found;
    slot_t                   free_slot;
  } tok_t;

  // table entry write, broadcast to all cells
  typedef struct packed {
    logic                    en;
    slot_t                   slot;
    logic [CIDX_W-1:0]       cidx;
    logic [GID_W-1:0]        gid;
    logic [WORKER_W-1:0]     worker;
  } wr_t;

endpackage
`default_nettype wire

/* hw/rtl/trg_cell.sv */
// one affinity table entry with its stage of the lookup chain
`default_nettype none
module trg_cell import trg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire slot_t cell_idx,
  input  wire tok_t  tok_i,
  input  wire wr_t   wr_i,
  output tok_t       tok_o
);

  logic                valid_r;
  logic [CIDX_W-1:0]   cidx_r;
  logic [GID_W-1:0]    gid_r;
  logic [WORKER_W-1:0] worker_r;
  tok_t                tok_r;
  tok_t                tok_nxt;
  logic                match;
  logic                wr_here;

  assign wr_here = wr_i.en && (wr_i.slot == cell_idx);
  assign match   = valid_r && (cidx_r == tok_i.cidx) && (gid_r == tok_i.gid);

  always_comb begin
    tok_nxt = tok_i;
    // first matching entry wins
    if (!tok_i.hit && match) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.worker = worker_r;
    end
    // first free entry wins
    if (!tok_i.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_slot  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      if (wr_here) begin
        valid_r <= 1'b1;
      end
      tok_r.vld <= tok_nxt.vld;
    end
    // entry contents and token payload need no reset
    if (wr_here) begin
      cidx_r   <= wr_i.cidx;
      gid_r    <= wr_i.gid;
      worker_r <= wr_i.worker;
    end
    tok_r.cidx       <= tok_nxt.cidx;
    tok_r.gid        <= tok_nxt.gid;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.worker     <= tok_nxt.worker;
    tok_r.free_found <= tok_nxt.free_found;
    tok_r.free_slot  <= tok_nxt.free_slot;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

/* hw/rtl/task_router_with_group_affinity.sv */
// task router top level: lookup chain, routing rules and result register
//
// One task is routed per command. A task is taken when start is high and
// busy is low; its (container, group) pair then walks down a chain of
// GROUP_ENTRIES table cells, one cell per cycle, collecting the first
// pinned match and the first free entry on the way. The cycle after the
// token leaves the last cell the routing rules are applied, the table and
// round-robin pointer are updated and the result is registered; out_valid
// is high for exactly that one following cycle, and the receiver cannot
// stall it. A new task may be started in the same cycle its predecessor's
// result is shown. The table is empty after reset with no clearing pass.
// Configuration is written through cfg_we, cfg_idx and cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce.
`default_nettype none
module task_router_with_group_affinity import trg_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // command channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_task_present,
  input  wire logic                       in_container_present,
  input  wire logic [CIDX_W-1:0]          in_container_index,
  input  wire logic                       in_has_group,
  input  wire logic signed [GID_W-1:0]    in_group_num,
  input  wire logic                       in_is_periodic,
  input  wire logic [POOL_W-1:0]          in_pool_id,
  input  wire logic [METHOD_W-1:0]        in_method_num,
  input  wire logic [IO_W-1:0]            in_io_size,
  // result channel
  output logic                            out_valid,
  output logic [WORKER_W-1:0]             out_worker_id,
  output logic                            out_pinned_hit,
  output logic                            out_table_full,
  // configuration port
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [CFG_W-1:0]           cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [CNT_W-1:0]    total_workers_r;
  logic [IO_W-1:0]     io_threshold_r;
  logic [POOL_W-1:0]   admin_pool_r;

  // task fields held for the decision at the end of the walk
  logic                task_r;
  logic                grouped_r;
  logic                periodic_r;
  logic [POOL_W-1:0]   pool_r;
  logic [METHOD_W-1:0] method_r;
  logic [IO_W-1:0]     io_r;
  logic [CIDX_W-1:0]   cidx_r;
  logic [GID_W-1:0]    gid_r;

  logic [WORKER_W-1:0] rr_r, rr_nxt;

  logic                out_valid_r;
  logic [WORKER_W-1:0] out_worker_r, out_worker_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_full_r, out_full_nxt;

  logic                accept;
  logic                grouped_in;
  logic                done;
  tok_t                chain [GROUP_ENTRIES+1];
  tok_t                last;
  wr_t                 wr;

  // decision intermediates
  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W-1:0]    io_count;
  logic                net_task;
  logic                large_io;
  logic [WORKER_W-1:0] rr_idx;
  logic [WORKER_W-1:0] sel;

  assign accept     = start && !busy;
  assign busy       = state_r[1];
  assign grouped_in = in_task_present && in_container_present && in_has_group &&
                      (32'(in_container_index) < CONTAINERS);

  // token enters the first cell at the transfer
  assign chain[0] = '{vld: accept, cidx: in_container_index, gid: in_group_num,
                      default: '0};

  for (genvar g = 0; g < GROUP_ENTRIES; g++) begin : g_cell
    trg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(g)),
      .tok_i    (chain[g]),
      .wr_i     (wr),
      .tok_o    (chain[g+1])
    );
  end

  assign last = chain[GROUP_ENTRIES];
  assign done = state_r[1] && last.vld;

  // routing rules
  always_comb begin
    n_eff = total_workers_r;
    if (total_workers_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(total_workers_r) > MAX_WORKERS) begin
      n_eff = CNT_W'(MAX_WORKERS);
    end
    io_count = (n_eff > CNT_W'(2)) ? (n_eff - CNT_W'(2)) : '0;

    net_task = task_r && periodic_r && (pool_r == admin_pool_r) &&
               ((method_r == METHOD_NET_A) || (method_r == METHOD_NET_B) ||
                (method_r == METHOD_NET_C) || (method_r == METHOD_NET_D));
    large_io = task_r && (io_count != '0) && (io_r >= io_threshold_r);

    // stale pointer falls back to the first I/O worker
    rr_idx = ({1'b0, rr_r} < io_count) ? rr_r : '0;
    sel    = large_io ? (rr_idx + WORKER_W'(1)) : '0;

    rr_nxt         = rr_r;
    out_worker_nxt = '0;
    out_hit_nxt    = 1'b0;
    out_full_nxt   = 1'b0;
    wr             = '0;
    wr.slot        = last.free_slot;
    wr.cidx        = cidx_r;
    wr.gid         = gid_r;
    wr.worker      = sel;

    if (grouped_r && last.hit) begin
      out_worker_nxt = last.worker;
      out_hit_nxt    = 1'b1;
    end else if (net_task) begin
      out_worker_nxt = WORKER_W'(n_eff - CNT_W'(1));
    end else begin
      out_worker_nxt = sel;
      if (large_io) begin
        rr_nxt = ({1'b0, rr_idx} + CNT_W'(1) == io_count) ? '0 :
                 (rr_idx + WORKER_W'(1));
      end
      if (grouped_r) begin
        if (last.free_found) begin
          wr.en = done;
        end else begin
          out_full_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (last.vld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      total_workers_r <= CNT_W'(8);
      io_threshold_r  <= IO_W'(65536);
      admin_pool_r    <= '0;
      rr_r            <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      if (done) begin
        rr_r <= rr_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_TOTAL_WORKERS: total_workers_r <= cfg_wdata[CNT_W-1:0];
          REG_IO_THRESHOLD:  io_threshold_r  <= cfg_wdata[IO_W-1:0];
          REG_ADMIN_POOL:    admin_pool_r    <= cfg_wdata[POOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      task_r     <= in_task_present;
      grouped_r  <= grouped_in;
      periodic_r <= in_is_periodic;
      pool_r     <= in_pool_id;
      method_r   <= in_method_num;
      io_r       <= in_io_size;
      cidx_r     <= in_container_index;
      gid_r      <= in_group_num;
    end
    if (done) begin
      out_worker_r <= out_worker_nxt;
      out_hit_r    <= out_hit_nxt;
      out_full_r   <= out_full_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_worker_id  = out_worker_r;
  assign out_pinned_hit = out_hit_r;
  assign out_table_full = out_full_r;

`ifndef SYNTHESIS
  // a result transfer closes a search
  a_out_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a search");

  // a pinned answer never reports a full table
  a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pinned_hit && out_table_full))
    else $error("pinned hit and table full together");

  // an accepted command starts the walk
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // the token leaves the chain only during a search
  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    last.vld |-> busy)
    else $error("lookup token outside a search");
`endif

endmodule
`default_nettype wire
